@@ rtl/pti_pkg.sv @@
// shared types and constants for the palindromic tree insert block
package pti_pkg;

    // fixed result and letter input field widths
    localparam int LEN_OUT_W   = 13;
    localparam int CNT_OUT_W   = 13;
    localparam int TOTAL_W     = 24;
    localparam int LETTER_IN_W = 5;

    // reserved node indexes
    localparam int ODD_ROOT   = 1;
    localparam int EVEN_ROOT  = 2;
    localparam int FIRST_NODE = 3;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NODE_RD,
        ST_NODE_EVAL,
        ST_TEXT_CMP,
        ST_CHILD_RD,
        ST_CHILD_EVAL,
        ST_CHK_EVAL,
        ST_WRITE,
        ST_FIN
    } pti_state_t;

endpackage

@@ rtl/pti_text_mem.sv @@
// text store: one letter per position, one write and one registered read port
module pti_text_mem
    import pti_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int DW    = 5
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/pti_child_mem.sv @@
// child table: node index per (node, letter), one write and one registered read port
module pti_child_mem
    import pti_pkg::*;
#(
    parameter int DEPTH = 106548,
    parameter int DW    = 13
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DW-1:0]            wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DW-1:0]            rd_data
);

    logic [DW-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ rtl/pti_node_mem.sv @@
// node attribute memory: length, suffix link, suffix count, parent, letter
module pti_node_mem
    import pti_pkg::*;
#(
    parameter int NODES = 4099,
    parameter int LW    = 13,
    parameter int CW    = 5
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(NODES)-1:0] wr_addr,
    input  logic [LW-1:0]            wr_len,
    input  logic [$clog2(NODES)-1:0] wr_link,
    input  logic [LW-1:0]            wr_cnt,
    input  logic [$clog2(NODES)-1:0] wr_parent,
    input  logic [CW-1:0]            wr_letter,
    input  logic [$clog2(NODES)-1:0] rd_addr,
    output logic [LW-1:0]            rd_len,
    output logic [$clog2(NODES)-1:0] rd_link,
    output logic [LW-1:0]            rd_cnt,
    output logic [$clog2(NODES)-1:0] rd_parent,
    output logic [CW-1:0]            rd_letter
);

    localparam int NW = $clog2(NODES);
    localparam int EW = 2 * LW + 2 * NW + CW;

    logic [EW-1:0] mem [NODES];
    logic [EW-1:0] rd_word;
    logic [NW-1:0] rd_addr_q;
    logic          is_root;

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_len, wr_link, wr_cnt, wr_parent, wr_letter};
        end
        rd_word   <= mem[rd_addr];
        rd_addr_q <= rd_addr;
    end

    // roots are constants: length 0 or unused, link to odd root, count zero
    assign is_root = (rd_addr_q == NW'(ODD_ROOT)) || (rd_addr_q == NW'(EVEN_ROOT));

    always_comb begin
        if (is_root) begin
            rd_len    = '0;
            rd_link   = NW'(ODD_ROOT);
            rd_cnt    = '0;
            rd_parent = '0;
            rd_letter = '0;
        end else begin
            {rd_len, rd_link, rd_cnt, rd_parent, rd_letter} = rd_word;
        end
    end

endmodule

@@ rtl/pti_ctrl.sv @@
// sequencer: suffix link walks, child lookup, node creation and result beat
module pti_ctrl
    import pti_pkg::*;
#(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input beat
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [LETTER_IN_W-1:0]      s_letter,
    input  logic                        s_restart,
    // result beat
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [LEN_OUT_W-1:0]        m_longest_pal_suffix,
    output logic                        m_new_palindrome,
    output logic [CNT_OUT_W-1:0]        m_pal_suffix_count,
    output logic [TOTAL_W-1:0]          m_total_palindromes,
    output logic                        m_store_full,
    // text memory
    output logic                        txt_wr_en,
    output logic [$clog2(MAX_LEN)-1:0]  txt_wr_addr,
    output logic [$clog2(ALPHABET)-1:0] txt_wr_data,
    output logic [$clog2(MAX_LEN)-1:0]  txt_rd_addr,
    input  logic [$clog2(ALPHABET)-1:0] txt_rd_data,
    // child memory
    output logic                                    chd_wr_en,
    output logic [$clog2((MAX_LEN+3)*ALPHABET)-1:0] chd_wr_addr,
    output logic [$clog2(MAX_LEN+3)-1:0]            chd_wr_data,
    output logic [$clog2((MAX_LEN+3)*ALPHABET)-1:0] chd_rd_addr,
    input  logic [$clog2(MAX_LEN+3)-1:0]            chd_rd_data,
    // node memory
    output logic                          nd_wr_en,
    output logic [$clog2(MAX_LEN+3)-1:0]  nd_wr_addr,
    output logic [$clog2(MAX_LEN+1)-1:0]  nd_wr_len,
    output logic [$clog2(MAX_LEN+3)-1:0]  nd_wr_link,
    output logic [$clog2(MAX_LEN+1)-1:0]  nd_wr_cnt,
    output logic [$clog2(MAX_LEN+3)-1:0]  nd_wr_parent,
    output logic [$clog2(ALPHABET)-1:0]   nd_wr_letter,
    output logic [$clog2(MAX_LEN+3)-1:0]  nd_rd_addr,
    input  logic [$clog2(MAX_LEN+1)-1:0]  nd_rd_len,
    input  logic [$clog2(MAX_LEN+3)-1:0]  nd_rd_link,
    input  logic [$clog2(MAX_LEN+1)-1:0]  nd_rd_cnt,
    input  logic [$clog2(MAX_LEN+3)-1:0]  nd_rd_parent,
    input  logic [$clog2(ALPHABET)-1:0]   nd_rd_letter
);

    localparam int NODES = MAX_LEN + 3;
    localparam int NW    = $clog2(NODES);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int PW    = $clog2(MAX_LEN);
    localparam int CW    = $clog2(ALPHABET);
    localparam int AW    = $clog2(NODES * ALPHABET);

    pti_state_t state_reg, state_next;

    logic          phase_reg, phase_next;
    logic [NW-1:0] wk_reg, wk_next;
    logic [NW-1:0] wk_link_reg, wk_link_next;
    logic [LW-1:0] wk_len_reg, wk_len_next;
    logic [NW-1:0] cur_reg, cur_next;
    logic [NW-1:0] cur_link_reg, cur_link_next;
    logic [LW-1:0] cur_len_reg, cur_len_next;
    logic [CW-1:0] let_reg, let_next;
    logic [LW-1:0] pos_reg, pos_next;
    logic [NW-1:0] lsn_reg, lsn_next;
    logic [NW-1:0] last_reg, last_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [NW-1:0] cand_reg, cand_next;
    logic [NW-1:0] res_node_reg, res_node_next;
    logic [LW-1:0] res_len_reg, res_len_next;
    logic [LW-1:0] res_cnt_reg, res_cnt_next;
    logic [NW-1:0] new_link_reg, new_link_next;
    logic          created_reg, created_next;
    logic          full_reg, full_next;

    logic                 m_valid_reg, m_valid_next;
    logic [LEN_OUT_W-1:0] m_len_reg, m_len_next;
    logic                 m_new_reg, m_new_next;
    logic [CNT_OUT_W-1:0] m_cnt_reg, m_cnt_next;
    logic [TOTAL_W-1:0]   m_total_reg, m_total_next;
    logic                 m_full_reg, m_full_next;

    logic [CW-1:0] let_sat;
    logic [LW-1:0] pos_eff;
    logic [LW-1:0] new_len;
    logic [NW-1:0] new_node;
    logic          out_free;
    logic          cand_ok;
    logic          chk_ok;

    // letters past the alphabet saturate to the last letter
    assign let_sat = (32'(s_letter) >= ALPHABET) ? CW'(ALPHABET - 1) : CW'(s_letter);
    assign pos_eff = s_restart ? '0 : pos_reg;

    // length of a node made under cur: odd root gives single letters
    assign new_len  = (cur_reg == NW'(ODD_ROOT)) ? LW'(1) : cur_len_reg + LW'(2);
    assign new_node = last_reg + NW'(1);

    // a child entry counts only if it names a node of the current tree
    assign cand_ok = (chd_rd_data >= NW'(FIRST_NODE)) && (chd_rd_data <= last_reg);
    assign chk_ok  = (nd_rd_parent == wk_reg) && (nd_rd_letter == let_reg);

    assign out_free = !m_valid_reg || m_ready;

    // state and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            lsn_reg     <= NW'(EVEN_ROOT);
            last_reg    <= NW'(EVEN_ROOT);
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            lsn_reg     <= lsn_next;
            last_reg    <= last_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
        phase_reg    <= phase_next;
        wk_reg       <= wk_next;
        wk_link_reg  <= wk_link_next;
        wk_len_reg   <= wk_len_next;
        cur_reg      <= cur_next;
        cur_link_reg <= cur_link_next;
        cur_len_reg  <= cur_len_next;
        let_reg      <= let_next;
        cand_reg     <= cand_next;
        res_node_reg <= res_node_next;
        res_len_reg  <= res_len_next;
        res_cnt_reg  <= res_cnt_next;
        new_link_reg <= new_link_next;
        created_reg  <= created_next;
        full_reg     <= full_next;
        m_len_reg    <= m_len_next;
        m_new_reg    <= m_new_next;
        m_cnt_reg    <= m_cnt_next;
        m_total_reg  <= m_total_next;
        m_full_reg   <= m_full_next;
    end

    // next state, datapath and memory controls
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        wk_next       = wk_reg;
        wk_link_next  = wk_link_reg;
        wk_len_next   = wk_len_reg;
        cur_next      = cur_reg;
        cur_link_next = cur_link_reg;
        cur_len_next  = cur_len_reg;
        let_next      = let_reg;
        pos_next      = pos_reg;
        lsn_next      = lsn_reg;
        last_next     = last_reg;
        total_next    = total_reg;
        cand_next     = cand_reg;
        res_node_next = res_node_reg;
        res_len_next  = res_len_reg;
        res_cnt_next  = res_cnt_reg;
        new_link_next = new_link_reg;
        created_next  = created_reg;
        full_next     = full_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_len_next    = m_len_reg;
        m_new_next    = m_new_reg;
        m_cnt_next    = m_cnt_reg;
        m_total_next  = m_total_reg;
        m_full_next   = m_full_reg;

        s_ready      = (state_reg == ST_IDLE);
        txt_wr_en    = 1'b0;
        txt_wr_addr  = PW'(pos_eff);
        txt_wr_data  = let_sat;
        txt_rd_addr  = PW'(pos_reg - LW'(1) - nd_rd_len);
        chd_wr_en    = 1'b0;
        chd_wr_addr  = AW'(cur_reg) * AW'(ALPHABET) + AW'(let_reg);
        chd_wr_data  = new_node;
        chd_rd_addr  = AW'(wk_reg) * AW'(ALPHABET) + AW'(let_reg);
        nd_wr_en     = 1'b0;
        nd_wr_addr   = new_node;
        nd_wr_len    = res_len_reg;
        nd_wr_link   = new_link_reg;
        nd_wr_cnt    = res_cnt_reg;
        nd_wr_parent = cur_reg;
        nd_wr_letter = let_reg;
        nd_rd_addr   = (state_reg == ST_CHILD_EVAL) ? chd_rd_data : wk_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    let_next     = let_sat;
                    pos_next     = pos_eff;
                    created_next = 1'b0;
                    phase_next   = 1'b0;
                    if (s_restart) begin
                        lsn_next   = NW'(EVEN_ROOT);
                        last_next  = NW'(EVEN_ROOT);
                        total_next = '0;
                    end
                    wk_next = s_restart ? NW'(EVEN_ROOT) : lsn_reg;
                    if (32'(pos_eff) >= MAX_LEN) begin
                        full_next  = 1'b1;
                        state_next = ST_FIN;
                    end else begin
                        full_next  = 1'b0;
                        txt_wr_en  = 1'b1;
                        state_next = ST_NODE_RD;
                    end
                end
            end
            ST_NODE_RD: begin
                state_next = ST_NODE_EVAL;
            end
            // node data: odd root always extends, else text compare or link step
            ST_NODE_EVAL: begin
                wk_len_next  = nd_rd_len;
                wk_link_next = nd_rd_link;
                if (wk_reg == NW'(ODD_ROOT)) begin
                    state_next = ST_CHILD_RD;
                end else if (nd_rd_len < pos_reg) begin
                    state_next = ST_TEXT_CMP;
                end else begin
                    wk_next    = nd_rd_link;
                    state_next = ST_NODE_RD;
                end
            end
            ST_TEXT_CMP: begin
                if (txt_rd_data == let_reg) begin
                    state_next = ST_CHILD_RD;
                end else begin
                    wk_next    = wk_link_reg;
                    state_next = ST_NODE_RD;
                end
            end
            ST_CHILD_RD: begin
                if (!phase_reg) begin
                    cur_next      = wk_reg;
                    cur_len_next  = wk_len_reg;
                    cur_link_next = wk_link_reg;
                end
                state_next = ST_CHILD_EVAL;
            end
            // child entry back: verify it or fall through to the miss path
            ST_CHILD_EVAL: begin
                cand_next = chd_rd_data;
                if (cand_ok) begin
                    state_next = ST_CHK_EVAL;
                end else if (phase_reg) begin
                    new_link_next = NW'(EVEN_ROOT);
                    res_cnt_next  = LW'(1);
                    state_next    = ST_WRITE;
                end else begin
                    res_len_next = new_len;
                    if (cur_reg == NW'(ODD_ROOT)) begin
                        new_link_next = NW'(EVEN_ROOT);
                        res_cnt_next  = LW'(1);
                        state_next    = ST_WRITE;
                    end else begin
                        phase_next = 1'b1;
                        wk_next    = cur_link_reg;
                        state_next = ST_NODE_RD;
                    end
                end
            end
            ST_CHK_EVAL: begin
                if (phase_reg) begin
                    new_link_next = chk_ok ? cand_reg : NW'(EVEN_ROOT);
                    res_cnt_next  = (chk_ok ? nd_rd_cnt : '0) + LW'(1);
                    state_next    = ST_WRITE;
                end else if (chk_ok) begin
                    res_node_next = cand_reg;
                    res_len_next  = nd_rd_len;
                    res_cnt_next  = nd_rd_cnt;
                    state_next    = ST_FIN;
                end else begin
                    res_len_next = new_len;
                    if (cur_reg == NW'(ODD_ROOT)) begin
                        new_link_next = NW'(EVEN_ROOT);
                        res_cnt_next  = LW'(1);
                        state_next    = ST_WRITE;
                    end else begin
                        phase_next = 1'b1;
                        wk_next    = cur_link_reg;
                        state_next = ST_NODE_RD;
                    end
                end
            end
            // commit the new node and its parent's child entry
            ST_WRITE: begin
                nd_wr_en      = 1'b1;
                chd_wr_en     = 1'b1;
                last_next     = new_node;
                res_node_next = new_node;
                created_next  = 1'b1;
                state_next    = ST_FIN;
            end
            // update tree state unless the store is full, and load the result beat
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_full_next  = full_reg;
                    if (full_reg) begin
                        m_len_next   = '0;
                        m_new_next   = 1'b0;
                        m_cnt_next   = '0;
                        m_total_next = total_reg;
                    end else begin
                        lsn_next     = res_node_reg;
                        pos_next     = pos_reg + LW'(1);
                        total_next   = total_reg + TOTAL_W'(res_cnt_reg);
                        m_len_next   = LEN_OUT_W'(res_len_reg);
                        m_new_next   = created_reg;
                        m_cnt_next   = CNT_OUT_W'(res_cnt_reg);
                        m_total_next = total_reg + TOTAL_W'(res_cnt_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid              = m_valid_reg;
    assign m_longest_pal_suffix = m_len_reg;
    assign m_new_palindrome     = m_new_reg;
    assign m_pal_suffix_count   = m_cnt_reg;
    assign m_total_palindromes  = m_total_reg;
    assign m_store_full         = m_full_reg;

endmodule

@@ rtl/palindromic_tree_insert.sv @@
// palindromic tree over a letter stream: sequencer plus text, child and node memories
// accepting edge to m_valid: a refused letter goes straight to the result load; else a node
// read per suffix link step (plus a text compare), a child read, a stored child check and
// the result load, and for a new node a second walk and child read for its link and a write
// one letter in flight; a result waits for a free output register
// reset: synchronous active low, empty tree; no clearing pass, child entries are validated
module palindromic_tree_insert
    import pti_pkg::*;
#(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [LETTER_IN_W-1:0] s_letter,
    input  logic                   s_restart,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [LEN_OUT_W-1:0]   m_longest_pal_suffix,
    output logic                   m_new_palindrome,
    output logic [CNT_OUT_W-1:0]   m_pal_suffix_count,
    output logic [TOTAL_W-1:0]     m_total_palindromes,
    output logic                   m_store_full
);

    localparam int NODES = MAX_LEN + 3;
    localparam int NW    = $clog2(NODES);
    localparam int LW    = $clog2(MAX_LEN + 1);
    localparam int PW    = $clog2(MAX_LEN);
    localparam int CW    = $clog2(ALPHABET);
    localparam int AW    = $clog2(NODES * ALPHABET);

    logic          txt_wr_en;
    logic [PW-1:0] txt_wr_addr;
    logic [CW-1:0] txt_wr_data;
    logic [PW-1:0] txt_rd_addr;
    logic [CW-1:0] txt_rd_data;
    logic          chd_wr_en;
    logic [AW-1:0] chd_wr_addr;
    logic [NW-1:0] chd_wr_data;
    logic [AW-1:0] chd_rd_addr;
    logic [NW-1:0] chd_rd_data;
    logic          nd_wr_en;
    logic [NW-1:0] nd_wr_addr;
    logic [LW-1:0] nd_wr_len;
    logic [NW-1:0] nd_wr_link;
    logic [LW-1:0] nd_wr_cnt;
    logic [NW-1:0] nd_wr_parent;
    logic [CW-1:0] nd_wr_letter;
    logic [NW-1:0] nd_rd_addr;
    logic [LW-1:0] nd_rd_len;
    logic [NW-1:0] nd_rd_link;
    logic [LW-1:0] nd_rd_cnt;
    logic [NW-1:0] nd_rd_parent;
    logic [CW-1:0] nd_rd_letter;

    pti_ctrl #(
        .MAX_LEN  (MAX_LEN),
        .ALPHABET (ALPHABET)
    ) u_ctrl (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_letter             (s_letter),
        .s_restart            (s_restart),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_longest_pal_suffix (m_longest_pal_suffix),
        .m_new_palindrome     (m_new_palindrome),
        .m_pal_suffix_count   (m_pal_suffix_count),
        .m_total_palindromes  (m_total_palindromes),
        .m_store_full         (m_store_full),
        .txt_wr_en            (txt_wr_en),
        .txt_wr_addr          (txt_wr_addr),
        .txt_wr_data          (txt_wr_data),
        .txt_rd_addr          (txt_rd_addr),
        .txt_rd_data          (txt_rd_data),
        .chd_wr_en            (chd_wr_en),
        .chd_wr_addr          (chd_wr_addr),
        .chd_wr_data          (chd_wr_data),
        .chd_rd_addr          (chd_rd_addr),
        .chd_rd_data          (chd_rd_data),
        .nd_wr_en             (nd_wr_en),
        .nd_wr_addr           (nd_wr_addr),
        .nd_wr_len            (nd_wr_len),
        .nd_wr_link           (nd_wr_link),
        .nd_wr_cnt            (nd_wr_cnt),
        .nd_wr_parent         (nd_wr_parent),
        .nd_wr_letter         (nd_wr_letter),
        .nd_rd_addr           (nd_rd_addr),
        .nd_rd_len            (nd_rd_len),
        .nd_rd_link           (nd_rd_link),
        .nd_rd_cnt            (nd_rd_cnt),
        .nd_rd_parent         (nd_rd_parent),
        .nd_rd_letter         (nd_rd_letter)
    );

    pti_text_mem #(
        .DEPTH (MAX_LEN),
        .DW    (CW)
    ) u_text_mem (
        .aclk    (aclk),
        .wr_en   (txt_wr_en),
        .wr_addr (txt_wr_addr),
        .wr_data (txt_wr_data),
        .rd_addr (txt_rd_addr),
        .rd_data (txt_rd_data)
    );

    pti_child_mem #(
        .DEPTH (NODES * ALPHABET),
        .DW    (NW)
    ) u_child_mem (
        .aclk    (aclk),
        .wr_en   (chd_wr_en),
        .wr_addr (chd_wr_addr),
        .wr_data (chd_wr_data),
        .rd_addr (chd_rd_addr),
        .rd_data (chd_rd_data)
    );

    pti_node_mem #(
        .NODES (NODES),
        .LW    (LW),
        .CW    (CW)
    ) u_node_mem (
        .aclk      (aclk),
        .wr_en     (nd_wr_en),
        .wr_addr   (nd_wr_addr),
        .wr_len    (nd_wr_len),
        .wr_link   (nd_wr_link),
        .wr_cnt    (nd_wr_cnt),
        .wr_parent (nd_wr_parent),
        .wr_letter (nd_wr_letter),
        .rd_addr   (nd_rd_addr),
        .rd_len    (nd_rd_len),
        .rd_link   (nd_rd_link),
        .rd_cnt    (nd_rd_cnt),
        .rd_parent (nd_rd_parent),
        .rd_letter (nd_rd_letter)
    );

endmodule

@@ sim/pti_checker.sv @@
// checker for the palindromic tree block: predicts each letter's result and compares
module pti_checker
    import pti_pkg::*;
#(
    parameter int MAX_LEN  = 4096,
    parameter int ALPHABET = 26
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [LETTER_IN_W-1:0] s_letter,
    input  logic                   s_restart,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic [LEN_OUT_W-1:0]   m_longest_pal_suffix,
    input  logic                   m_new_palindrome,
    input  logic [CNT_OUT_W-1:0]   m_pal_suffix_count,
    input  logic [TOTAL_W-1:0]     m_total_palindromes,
    input  logic                   m_store_full,
    output int                     fail_count,
    output int                     pending
);

    localparam int NODES = MAX_LEN + 3;

    typedef struct {
        logic [LEN_OUT_W-1:0] pal_len;
        logic                 created;
        logic [CNT_OUT_W-1:0] suffix_cnt;
        logic [TOTAL_W-1:0]   total;
        logic                 full;
    } pal_result_t;

    // model of the tree
    logic [4:0] text_mem [MAX_LEN];
    int         node_len [NODES];
    int         node_link [NODES];
    int         node_cnt [NODES];
    int         child_of [int];
    int         longest_node;
    int         last_node;
    int         text_pos;
    int         pal_total;

    pal_result_t expected_results [$];

    function automatic bit wraps(int v, int pos, int ltr);
        int idx;
        idx = pos - 1 - node_len[v];
        if (idx < 0 || idx >= MAX_LEN) return 0;
        return text_mem[idx] == ltr;
    endfunction

    function automatic int child_key(int v, int ltr);
        return v * 32 + ltr;
    endfunction

    function automatic int child_get(int v, int ltr);
        if (child_of.exists(child_key(v, ltr))) return child_of[child_key(v, ltr)];
        return 0;
    endfunction

    function automatic void clear_tree();
        child_of.delete();
        node_len[ODD_ROOT]   = -1;
        node_len[EVEN_ROOT]  = 0;
        node_link[ODD_ROOT]  = ODD_ROOT;
        node_link[EVEN_ROOT] = ODD_ROOT;
        node_cnt[ODD_ROOT]   = 0;
        node_cnt[EVEN_ROOT]  = 0;
        longest_node = EVEN_ROOT;
        last_node    = EVEN_ROOT;
        text_pos     = 0;
        pal_total    = 0;
    endfunction

    // one letter through the tree
    function automatic pal_result_t insert_letter(int ltr, bit restart);
        pal_result_t r;
        int cur, node, w, lk;
        r.created = 0;
        if (ltr >= ALPHABET) ltr = ALPHABET - 1;
        if (restart) clear_tree();
        if (text_pos >= MAX_LEN) begin
            r.pal_len    = '0;
            r.suffix_cnt = '0;
            r.total      = pal_total[TOTAL_W-1:0];
            r.full       = 1;
            return r;
        end
        text_mem[text_pos] = ltr[4:0];
        cur = longest_node;
        while (!wraps(cur, text_pos, ltr) && cur != ODD_ROOT) cur = node_link[cur];
        node = child_get(cur, ltr);
        if (node == 0 && last_node + 1 < NODES) begin
            r.created = 1;
            last_node++;
            node = last_node;
            node_len[node] = node_len[cur] + 2;
            child_of[child_key(cur, ltr)] = node;
            if (node_len[node] == 1) begin
                node_link[node] = EVEN_ROOT;
                node_cnt[node]  = 1;
            end else begin
                w = cur;
                do w = node_link[w]; while (!wraps(w, text_pos, ltr) && w != ODD_ROOT);
                lk = child_get(w, ltr);
                if (lk == 0 || lk == node) lk = EVEN_ROOT;
                node_link[node] = lk;
                node_cnt[node]  = 1 + node_cnt[lk];
            end
        end
        if (node == 0) node = EVEN_ROOT;
        longest_node = node;
        text_pos++;
        pal_total += node_cnt[node];
        r.pal_len    = node_len[node][LEN_OUT_W-1:0];
        r.suffix_cnt = node_cnt[node][CNT_OUT_W-1:0];
        r.total      = pal_total[TOTAL_W-1:0];
        r.full       = 0;
        return r;
    endfunction

    // predict on input beats, compare on result beats
    always @(posedge aclk) begin
        pal_result_t want;
        if (!aresetn) begin
            clear_tree();
            expected_results.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (s_valid && s_ready) expected_results.push_back(insert_letter(s_letter, s_restart));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (m_longest_pal_suffix !== want.pal_len ||
                        m_new_palindrome !== want.created ||
                        m_pal_suffix_count !== want.suffix_cnt ||
                        m_total_palindromes !== want.total ||
                        m_store_full !== want.full)
                        fail_count <= fail_count + 1;
                    if (m_longest_pal_suffix !== want.pal_len)
                        $error("longest_pal_suffix expected %0d got %0d",
                               want.pal_len, m_longest_pal_suffix);
                    if (m_new_palindrome !== want.created)
                        $error("new_palindrome expected %0d got %0d",
                               want.created, m_new_palindrome);
                    if (m_pal_suffix_count !== want.suffix_cnt)
                        $error("pal_suffix_count expected %0d got %0d",
                               want.suffix_cnt, m_pal_suffix_count);
                    if (m_total_palindromes !== want.total)
                        $error("total_palindromes expected %0d got %0d",
                               want.total, m_total_palindromes);
                    if (m_store_full !== want.full)
                        $error("store_full expected %0d got %0d", want.full, m_store_full);
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

@@ sim/testbench.sv @@
// top of the palindromic tree testbench: clock, reset, letter stream and verdict
module testbench
    import pti_pkg::*;
;

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic                   s_valid = 0;
    logic                   s_ready;
    logic [LETTER_IN_W-1:0] s_letter = '0;
    logic                   s_restart = 0;
    logic                   m_valid;
    logic                   m_ready = 0;
    logic [LEN_OUT_W-1:0]   m_longest_pal_suffix;
    logic                   m_new_palindrome;
    logic [CNT_OUT_W-1:0]   m_pal_suffix_count;
    logic [TOTAL_W-1:0]     m_total_palindromes;
    logic                   m_store_full;
    int                     fail_count;
    int                     pending;

    // idling phase: 0 sender light/receiver heavy, 1 swapped, 2 none
    int send_idle_pct = 20;
    int recv_idle_pct = 62;
    int stall_left = 0;
    bit stall_done = 0;

    always #2 aclk = ~aclk;

    palindromic_tree_insert DUT (.*);

    pti_checker checker_i (.*);

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 0;
        end else if (!stall_done && send_idle_pct == 62) begin
            stall_done <= 1;
            stall_left <= 300;
            m_ready    <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one letter beat and wait for it to be taken
    task automatic send_letter(int ltr, bit restart);
        bit rdy;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid   <= 1;
        s_letter  <= ltr[LETTER_IN_W-1:0];
        s_restart <= restart;
        do begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
        end while (!rdy);
    endtask

    initial begin
        int hi;
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: repeats, odd/even palindromes, alphabet extremes, saturation, restart
        send_letter(0, 1);
        send_letter(0, 0);
        send_letter(0, 0);
        send_letter(1, 0);
        send_letter(0, 0);
        send_letter(0, 0);
        send_letter(1, 0);
        send_letter(0, 0);
        send_letter(25, 0);
        send_letter(31, 0);
        send_letter(26, 0);
        send_letter(25, 0);
        send_letter(21, 0);
        send_letter(10, 1);
        send_letter(10, 0);
        send_letter(31, 1);
        send_letter(30, 0);
        send_letter(15, 0);

        // random strings, mostly over narrow alphabets so palindromes grow deep
        for (int i = 0; i < 1980; i++) begin
            if (i == 660) begin
                send_idle_pct = 62;
                recv_idle_pct = 20;
            end else if (i == 1320) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (i % 60 == 0) hi = ($urandom_range(9) == 0) ? 31 : $urandom_range(3, 1);
            send_letter($urandom_range(hi), $urandom_range(59) == 0);
        end
        s_valid <= 0;

        // drain, then let the block settle
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
